[sv/ini_key_value_tokenizer_top_defines.svh]
// ----------------------------------------------------------------------------
// INI tokenizer assertion macros
// Concurrent assertion helpers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INI_KEY_VALUE_TOKENIZER_TOP_DEFINES_SVH
`define INI_KEY_VALUE_TOKENIZER_TOP_DEFINES_SVH

`ifndef SYNTH
`define IKVT_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ikvt assertion failed");
`define IKVT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ikvt assertion failed");
`define IKVT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ikvt assertion failed");
`else
`define IKVT_ASSERT_ALWAYS(lbl, expr)
`define IKVT_ASSERT_IMPL(lbl, ante, cons)
`define IKVT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/ikvt_pkg.sv]
// ----------------------------------------------------------------------------
// INI tokenizer package
// Shared types, character codes and sizes of the INI key/value tokenizer.
// ----------------------------------------------------------------------------
package ikvt_pkg;

   localparam int LINE_BITS = 24;
   localparam int LINE_OUT_BITS = 24;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;

   localparam logic [7:0] SPACES_MAX = 8'hFF;

   typedef enum logic [3:0] {
      S_HDR_START      = 4'd0,
      S_HDR_SKIP       = 4'd1,
      S_IN_HDR         = 4'd2,
      S_AFTER_HDR      = 4'd3,
      S_AFTER_HDR_SKIP = 4'd4,
      S_LINE_START     = 4'd5,
      S_IN_KEY         = 4'd6,
      S_WANT_EQ        = 4'd7,
      S_LINE_SKIP      = 4'd8,
      S_WANT_VAL       = 4'd9,
      S_IN_VAL         = 4'd10
   } state_type;

   typedef enum logic [2:0] {
      K_HDR_CHAR  = 3'd0,
      K_HDR_DONE  = 3'd1,
      K_KEY_CHAR  = 3'd2,
      K_VAL_CHAR  = 3'd3,
      K_PROP_DONE = 3'd4,
      K_ERROR     = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      E_BAD_HEADER = 2'd0,
      E_JUNK       = 2'd1,
      E_BAD_LINE   = 2'd2
   } err_type;

   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               tbyte;
      logic [7:0]               spaces;
      logic [LINE_OUT_BITS-1:0] line;
      err_type                  err;
   } token_type;

endpackage

[sv/ikvt_if.sv]
// ----------------------------------------------------------------------------
// INI tokenizer channel interfaces
// Valid/ready channels for text bytes in and tokens out.
// ----------------------------------------------------------------------------
interface ikvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ikvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [7:0]  token_byte;
   logic [7:0]  spaces_before;
   logic [23:0] token_line;
   logic [1:0]  error_code;

   modport source (output valid, output token_kind, output token_byte,
                   output spaces_before, output token_line, output error_code,
                   input ready);
   modport sink (input valid, input token_kind, input token_byte,
                 input spaces_before, input token_line, input error_code,
                 output ready);
endinterface

[sv/ikvt_parser.sv]
// ----------------------------------------------------------------------------
// INI tokenizer parser
// Parser state, line counter and pending value spaces, with the token that
// the current byte produces.
// ----------------------------------------------------------------------------
`include "ini_key_value_tokenizer_top_defines.svh"

module ikvt_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            text_byte,
   input  logic                  end_of_text,
   output logic                  tok_valid,
   output ikvt_pkg::token_type   tok
);

   ikvt_pkg::state_type              state_ff, state_in;
   logic [ikvt_pkg::LINE_BITS-1:0]   line_ff, line_in;
   logic [7:0]                       spaces_ff, spaces_in;

   logic [7:0]  ch;
   logic        nl;
   logic        sp;
   logic [31:0] line_wide;

   assign ch = end_of_text ? ikvt_pkg::CH_NEWLINE : text_byte;
   assign nl = (ch == ikvt_pkg::CH_NEWLINE);
   assign sp = (ch == ikvt_pkg::CH_SPACE);
   assign line_wide = 32'(line_ff);

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      spaces_in = spaces_ff;
      line_in = line_ff;
      case (state_ff)
         ikvt_pkg::S_HDR_START, ikvt_pkg::S_LINE_START: begin
            if (ch == ikvt_pkg::CH_LBRACKET) begin
               state_in = ikvt_pkg::S_IN_HDR;
            end else if (!sp && !nl) begin
               state_in = (state_ff == ikvt_pkg::S_HDR_START) ?
                          ikvt_pkg::S_HDR_SKIP : ikvt_pkg::S_IN_KEY;
            end
         end
         ikvt_pkg::S_HDR_SKIP: begin
            if (nl) state_in = ikvt_pkg::S_HDR_START;
         end
         ikvt_pkg::S_IN_HDR: begin
            if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
            end else if (ch == ikvt_pkg::CH_RBRACKET) begin
               state_in = ikvt_pkg::S_AFTER_HDR;
            end
         end
         ikvt_pkg::S_AFTER_HDR: begin
            if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
            end else if (!sp) begin
               state_in = ikvt_pkg::S_AFTER_HDR_SKIP;
            end
         end
         ikvt_pkg::S_IN_KEY: begin
            if (sp) begin
               state_in = ikvt_pkg::S_WANT_EQ;
            end else if (ch == ikvt_pkg::CH_EQUALS) begin
               state_in = ikvt_pkg::S_WANT_VAL;
            end else if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
            end
         end
         ikvt_pkg::S_WANT_EQ: begin
            if (ch == ikvt_pkg::CH_EQUALS) begin
               state_in = ikvt_pkg::S_WANT_VAL;
            end else if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
            end else if (!sp) begin
               state_in = ikvt_pkg::S_LINE_SKIP;
            end
         end
         ikvt_pkg::S_WANT_VAL: begin
            if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
            end else if (!sp) begin
               state_in = ikvt_pkg::S_IN_VAL;
               spaces_in = '0;
            end
         end
         ikvt_pkg::S_IN_VAL: begin
            if (nl) begin
               state_in = ikvt_pkg::S_LINE_START;
               spaces_in = '0;
            end else if (sp) begin
               if (spaces_ff != ikvt_pkg::SPACES_MAX) spaces_in = spaces_ff + 8'd1;
            end else begin
               spaces_in = '0;
            end
         end
         default: begin
            if (nl) state_in = ikvt_pkg::S_LINE_START;
         end
      endcase
      if (end_of_text) begin
         state_in = ikvt_pkg::S_HDR_START;
         spaces_in = '0;
         line_in = ikvt_pkg::LINE_BITS'(1);
      end else if (nl && (line_ff != '1)) begin
         line_in = line_ff + ikvt_pkg::LINE_BITS'(1);
      end
   end

   // Token for the current byte.
   always_comb begin
      tok_valid = 1'b0;
      tok.kind = ikvt_pkg::K_ERROR;
      tok.tbyte = '0;
      tok.spaces = '0;
      tok.line = line_wide[ikvt_pkg::LINE_OUT_BITS-1:0];
      tok.err = ikvt_pkg::E_BAD_HEADER;
      case (state_ff)
         ikvt_pkg::S_HDR_START, ikvt_pkg::S_LINE_START: begin
            if ((ch != ikvt_pkg::CH_LBRACKET) && !sp && !nl) begin
               tok_valid = 1'b1;
               if (state_ff == ikvt_pkg::S_HDR_START) begin
                  tok.kind = ikvt_pkg::K_ERROR;
                  tok.err = ikvt_pkg::E_BAD_HEADER;
               end else begin
                  tok.kind = ikvt_pkg::K_KEY_CHAR;
                  tok.tbyte = ch;
               end
            end
         end
         ikvt_pkg::S_IN_HDR: begin
            tok_valid = 1'b1;
            if (nl) begin
               tok.kind = ikvt_pkg::K_ERROR;
               tok.err = ikvt_pkg::E_BAD_HEADER;
            end else if (ch == ikvt_pkg::CH_RBRACKET) begin
               tok.kind = ikvt_pkg::K_HDR_DONE;
            end else begin
               tok.kind = ikvt_pkg::K_HDR_CHAR;
               tok.tbyte = ch;
            end
         end
         ikvt_pkg::S_AFTER_HDR: begin
            if (!nl && !sp) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_ERROR;
               tok.err = ikvt_pkg::E_JUNK;
            end
         end
         ikvt_pkg::S_IN_KEY: begin
            if (!sp && (ch != ikvt_pkg::CH_EQUALS)) begin
               tok_valid = 1'b1;
               if (nl) begin
                  tok.kind = ikvt_pkg::K_ERROR;
                  tok.err = ikvt_pkg::E_BAD_LINE;
               end else begin
                  tok.kind = ikvt_pkg::K_KEY_CHAR;
                  tok.tbyte = ch;
               end
            end
         end
         ikvt_pkg::S_WANT_EQ: begin
            if (!sp && (ch != ikvt_pkg::CH_EQUALS)) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_ERROR;
               tok.err = ikvt_pkg::E_BAD_LINE;
            end
         end
         ikvt_pkg::S_WANT_VAL: begin
            if (nl) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_PROP_DONE;
            end else if (!sp) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_VAL_CHAR;
               tok.tbyte = ch;
            end
         end
         ikvt_pkg::S_IN_VAL: begin
            if (nl) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_PROP_DONE;
            end else if (!sp) begin
               tok_valid = 1'b1;
               tok.kind = ikvt_pkg::K_VAL_CHAR;
               tok.tbyte = ch;
               tok.spaces = spaces_ff;
            end
         end
         default: begin
            tok_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ikvt_pkg::S_HDR_START;
         line_ff <= ikvt_pkg::LINE_BITS'(1);
         spaces_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         line_ff <= line_in;
         spaces_ff <= spaces_in;
      end
   end

   `IKVT_ASSERT_NEXT(a_eot_resets, accept && end_of_text,
      (state_ff == ikvt_pkg::S_HDR_START) && (line_ff == ikvt_pkg::LINE_BITS'(1)))
   `IKVT_ASSERT_IMPL(a_spaces_in_value, spaces_ff != 8'd0,
      state_ff == ikvt_pkg::S_IN_VAL)
   `IKVT_ASSERT_IMPL(a_no_token_when_skipping,
      (state_ff == ikvt_pkg::S_HDR_SKIP) || (state_ff == ikvt_pkg::S_LINE_SKIP), !tok_valid)

endmodule

[sv/ikvt_out_reg.sv]
// ----------------------------------------------------------------------------
// INI tokenizer result register
// Holds one token until the receiver takes it; drives input ready.
// ----------------------------------------------------------------------------
`include "ini_key_value_tokenizer_top_defines.svh"

module ikvt_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                tok_valid,
   input  ikvt_pkg::token_type tok,
   output logic                out_valid,
   input  logic                out_ready,
   output ikvt_pkg::token_type out_tok
);

   logic                valid_ff, valid_in;
   ikvt_pkg::token_type tok_ff;
   logic                load;

   assign in_ready = !valid_ff || out_ready;
   assign load = in_valid && in_ready && tok_valid;
   assign valid_in = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_tok = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= tok;
      end
   end

   `IKVT_ASSERT_IMPL(a_stall_blocks_input, valid_ff && !out_ready, !in_ready)
   `IKVT_ASSERT_IMPL(a_kind_legal, valid_ff,
      (tok_ff.kind != 3'd6) && (tok_ff.kind != 3'd7))
   `IKVT_ASSERT_IMPL(a_byte_only_for_chars,
      valid_ff && (tok_ff.kind != ikvt_pkg::K_HDR_CHAR) &&
      (tok_ff.kind != ikvt_pkg::K_KEY_CHAR) && (tok_ff.kind != ikvt_pkg::K_VAL_CHAR),
      (tok_ff.tbyte == 8'd0) && (tok_ff.spaces == 8'd0))

endmodule

[sv/ini_key_value_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// INI key/value tokenizer
// Feed INI text one byte per transaction on the req channel. Each byte gives
// zero or one token on the rsp channel: header characters, header done, key
// characters, value characters (with the count of spaces to insert before
// them), property done, or an error with a code. After an error the receiver
// discards any partial header or key. A transaction with end_of_text set acts
// as a final newline and then returns the parser and line counter to their
// reset values.
// The token of a byte accepted at one edge is valid after that edge. One
// byte is accepted every cycle unless the receiver stalls; the rate is set by
// the single parser state register updated per byte and the one-entry result
// register. While a token waits and the receiver stalls, req ready drops;
// a waiting token is taken and the next byte accepted at the same edge.
// Reset is synchronous: the parser returns to the header start state, the
// line count to one, and any held token is dropped.
// ----------------------------------------------------------------------------
module ini_key_value_tokenizer_top (
   input logic      clock,
   input logic      reset,
   ikvt_req_if.sink req_bus,
   ikvt_rsp_if.source rsp_bus
);

   logic                accept;
   logic                tok_valid;
   ikvt_pkg::token_type tok;
   ikvt_pkg::token_type out_tok;

   assign accept = req_bus.valid && req_bus.ready;

   ikvt_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .tok_valid   (tok_valid),
      .tok         (tok)
   );

   ikvt_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .tok_valid (tok_valid),
      .tok       (tok),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_tok   (out_tok)
   );

   assign rsp_bus.token_kind = out_tok.kind;
   assign rsp_bus.token_byte = out_tok.tbyte;
   assign rsp_bus.spaces_before = out_tok.spaces;
   assign rsp_bus.token_line = out_tok.line;
   assign rsp_bus.error_code = out_tok.err;

endmodule
